[rtl/core/fsig_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsig_pkg
// Shared constants and the magic signature table for the signature matcher.
// ----------------------------------------------------------------------------
package fsig_pkg;

    localparam int NUM_SIGNATURES = 59;
    localparam int POSITION_LIMIT = 263;
    localparam int POS_W          = 9;
    localparam int ROW_W          = 6;
    localparam int MAX_LEN        = 14;
    localparam int LEN_W          = 4;
    localparam int SIG_W          = MAX_LEN * 8;

    // byte 0 of a signature sits in the top byte of sig_bytes
    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic [LEN_W-1:0] count;
        logic [SIG_W-1:0] sig_bytes;
    } t_sig;

    localparam t_sig SIG_TABLE [0:NUM_SIGNATURES-1] = '{
        '{9'd28,  4'd8,  {64'h4F70757348656164, 48'h0}},
        '{9'd0,   4'd14, 112'h060E2B34020501010D0102010102},
        '{9'd0,   4'd11, {88'h0000001C667479704D3456, 24'h0}},
        '{9'd0,   4'd10, {80'h3026B2758E66CF11A6D9, 32'h0}},
        '{9'd0,   4'd8,  {64'h0000001466747970, 48'h0}},
        '{9'd0,   4'd8,  {64'hD0CF11E0A1B11AE1, 48'h0}},
        '{9'd0,   4'd7,  {56'h213C617263683E, 56'h0}},
        '{9'd4,   4'd7,  {56'h667479704D3441, 56'h0}},
        '{9'd0,   4'd6,  {48'h377ABCAF271C, 64'h0}},
        '{9'd0,   4'd6,  {48'hFD377A585A00, 64'h0}},
        '{9'd0,   4'd5,  {40'h2321414D52, 72'h0}},
        '{9'd0,   4'd5,  {40'h7B5C727466, 72'h0}},
        '{9'd257, 4'd5,  {40'h7573746172, 72'h0}},
        '{9'd0,   4'd5,  {40'h0001000000, 72'h0}},
        '{9'd0,   4'd4,  {32'h49536328, 80'h0}},
        '{9'd0,   4'd4,  {32'h4D534346, 80'h0}},
        '{9'd0,   4'd4,  {32'h43723234, 80'h0}},
        '{9'd0,   4'd4,  {32'h664C6143, 80'h0}},
        '{9'd0,   4'd4,  {32'h464C4946, 80'h0}},
        '{9'd0,   4'd4,  {32'h464C5601, 80'h0}},
        '{9'd0,   4'd4,  {32'h00000100, 80'h0}},
        '{9'd0,   4'd4,  {32'h4C5A4950, 80'h0}},
        '{9'd0,   4'd4,  {32'h4D344120, 80'h0}},
        '{9'd0,   4'd4,  {32'h4D546864, 80'h0}},
        '{9'd0,   4'd4,  {32'h1A45DFA3, 80'h0}},
        '{9'd0,   4'd4,  {32'h33677035, 80'h0}},
        '{9'd4,   4'd4,  {32'h66747970, 80'h0}},
        '{9'd0,   4'd4,  {32'h00000162, 80'h0}},
        '{9'd0,   4'd4,  {32'h4E45531A, 80'h0}},
        '{9'd0,   4'd4,  {32'h4F676753, 80'h0}},
        '{9'd0,   4'd4,  {32'h4F54544F, 80'h0}},
        '{9'd0,   4'd4,  {32'h25504446, 80'h0}},
        '{9'd0,   4'd4,  {32'h89504E47, 80'h0}},
        '{9'd0,   4'd4,  {32'h38425053, 80'h0}},
        '{9'd0,   4'd4,  {32'h52617221, 80'h0}},
        '{9'd0,   4'd4,  {32'hEDABEEDB, 80'h0}},
        '{9'd0,   4'd4,  {32'h53514C69, 80'h0}},
        '{9'd0,   4'd4,  {32'h3C737667, 80'h0}},
        '{9'd0,   4'd4,  {32'h49492A00, 80'h0}},
        '{9'd0,   4'd4,  {32'h4D4D002A, 80'h0}},
        '{9'd8,   4'd4,  {32'h57415645, 80'h0}},
        '{9'd8,   4'd4,  {32'h57454250, 80'h0}},
        '{9'd0,   4'd4,  {32'h774F4646, 80'h0}},
        '{9'd0,   4'd4,  {32'h774F4632, 80'h0}},
        '{9'd8,   4'd3,  {24'h415649, 88'h0}},
        '{9'd0,   4'd3,  {24'h425A68, 88'h0}},
        '{9'd0,   4'd3,  {24'h474946, 88'h0}},
        '{9'd0,   4'd3,  {24'h1F8B08, 88'h0}},
        '{9'd0,   4'd3,  {24'hFFD8FF, 88'h0}},
        '{9'd0,   4'd3,  {24'h4949BC, 88'h0}},
        '{9'd0,   4'd3,  {24'h494433, 88'h0}},
        '{9'd0,   4'd2,  {16'h424D, 96'h0}},
        '{9'd0,   4'd2,  {16'h7801, 96'h0}},
        '{9'd0,   4'd2,  {16'h4D5A, 96'h0}},
        '{9'd0,   4'd2,  {16'h2521, 96'h0}},
        '{9'd1,   4'd2,  {16'h5753, 96'h0}},
        '{9'd0,   4'd2,  {16'h1F9D, 96'h0}},
        '{9'd0,   4'd2,  {16'h1FA0, 96'h0}},
        '{9'd0,   4'd2,  {16'h504B, 96'h0}}
    };

endpackage

[rtl/core/fsig_row_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsig_row_cmp
// Compares one byte against every signature row at the current position and
// flags rows that are still matching and end before the stream length.
// ----------------------------------------------------------------------------
module fsig_row_cmp (
    input  logic [fsig_pkg::POS_W-1:0]          i_pos,
    input  logic [7:0]                          i_byte,
    input  logic [fsig_pkg::NUM_SIGNATURES-1:0] i_match,
    output logic [fsig_pkg::NUM_SIGNATURES-1:0] o_match,
    output logic [fsig_pkg::NUM_SIGNATURES-1:0] o_hit
);
    import fsig_pkg::*;

    always_comb begin
        logic [POS_W:0] pos_ext;
        logic [POS_W:0] row_end;
        logic           miss;
        pos_ext = {1'b0, i_pos};
        for (int r = 0; r < NUM_SIGNATURES; r++) begin
            miss = 1'b0;
            for (int j = 0; j < MAX_LEN; j++) begin
                // byte j of the row is checked only at its own position
                if ((LEN_W'(j) < SIG_TABLE[r].count) &&
                    (pos_ext == ((POS_W+1)'(SIG_TABLE[r].offset) + (POS_W+1)'(j))) &&
                    (i_byte != SIG_TABLE[r].sig_bytes[SIG_W-1-8*j -: 8])) begin
                    miss = 1'b1;
                end
            end
            o_match[r] = i_match[r] & ~miss;
            row_end    = (POS_W+1)'(SIG_TABLE[r].offset) + (POS_W+1)'(SIG_TABLE[r].count);
            // row must end strictly before length = pos + 1
            o_hit[r]   = o_match[r] & (row_end <= pos_ext);
        end
    end

endmodule

[rtl/core/fsig_first_hit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsig_first_hit
// Priority encoder that picks the lowest-numbered matching row.
// ----------------------------------------------------------------------------
module fsig_first_hit (
    input  logic [fsig_pkg::NUM_SIGNATURES-1:0] i_hit,
    output logic                                o_found,
    output logic [fsig_pkg::ROW_W-1:0]          o_row
);
    import fsig_pkg::*;

    always_comb begin
        o_row = '0;
        // scan downward so the lowest set row wins
        for (int r = NUM_SIGNATURES - 1; r >= 0; r--) begin
            if (i_hit[r]) begin
                o_row = ROW_W'(r);
            end
        end
        o_found = |i_hit;
    end

endmodule

[rtl/core/file_signature_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_signature_matcher
// Streams the head of a file byte by byte and reports which magic signature
// row, if any, matched once the last byte arrives.
// ----------------------------------------------------------------------------
// channel  dir  tdata            tuser   tlast
// s_axis   in   [7:0] data_byte  -       last_byte
// m_axis   out  [5:0] sig row    found   -
//
// one byte accepted per cycle unless a last byte waits on a stalled m_axis;
// an accepted request sits in the input register during compare; once the
// last byte leaves it, the result is registered in the output register.
// reset clears position to 0 and all row flags to set; the same happens
// after every last byte, so streams follow back to back.
// bytes that are not last pass a stalled m_axis; a last byte and input wait.
module file_signature_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] signature_row, [7:6] zero
    output logic       m_axis_tuser    // [0] found
);
    import fsig_pkg::*;

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;
    logic [POS_W-1:0]          r_pos;
    logic [NUM_SIGNATURES-1:0] r_match;
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [ROW_W-1:0]          r_out_row;

    logic [NUM_SIGNATURES-1:0] n_match;
    logic [NUM_SIGNATURES-1:0] hit;
    logic                      hit_found;
    logic [ROW_W-1:0]          hit_row;
    logic                      advance;
    logic [POS_W-1:0]          n_pos;

    // bytes that are not last never need the output slot
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign n_pos         = (r_pos < POS_W'(POSITION_LIMIT)) ? r_pos + 1'b1 : r_pos;

    fsig_row_cmp u_row_cmp (
        .i_pos   (r_pos),
        .i_byte  (r_in_byte),
        .i_match (r_match),
        .o_match (n_match),
        .o_hit   (hit)
    );

    fsig_first_hit u_first_hit (
        .i_hit   (hit),
        .o_found (hit_found),
        .o_row   (hit_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_match <= '1;
        end else if (advance) begin
            if (r_in_last) begin
                r_pos   <= '0;
                r_match <= '1;
            end else begin
                r_pos   <= n_pos;
                r_match <= n_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_found <= hit_found;
            r_out_row   <= hit_row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(8 - ROW_W)'(0), r_out_row};
    assign m_axis_tuser  = r_out_found;

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(POSITION_LIMIT))
        else $error("byte position beyond limit");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pos == '0 && r_match == '1 && r_out_valid))
        else $error("state not restored after last byte");

    a_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_row == '0))
        else $error("row not zero when nothing found");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_row < ROW_W'(NUM_SIGNATURES)))
        else $error("row index out of table");

endmodule

[test/tb_file_signature_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_signature_matcher
// Streams file heads into the matcher and checks every detection result.
// File heads carry magic signatures, sometimes two at once, sometimes with
// one bit broken, or are pure noise. A few run past the position limit to
// reach the tar signature. A local copy of the signature table and of the row
// flags predicts each result. Four flow-control phases are run: free flow, a
// stuttering sender, a stalling receiver, and both.
// ----------------------------------------------------------------------------
module tb_file_signature_matcher;

    import fsig_pkg::NUM_SIGNATURES;
    import fsig_pkg::POSITION_LIMIT;

    localparam int ITEMS_PER_PHASE = 410;
    localparam int USTAR_ROW       = 12;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int HEAD_MAX        = 384;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_head_byte;

    typedef struct packed {
        logic       found;
        logic [5:0] row;
    } t_match;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } t_flow_mode;

    typedef enum int {
        HEAD_LONG,
        HEAD_MAGIC,
        HEAD_TWO_MAGIC,
        HEAD_CORRUPT,
        HEAD_NOISE
    } t_head_kind;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;           // [5:0] signature_row, [7:6] zero
    logic       m_axis_tuser;           // [0] found

    file_signature_matcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // local signature table, byte 0 in the most significant used byte
    int         magic_off [NUM_SIGNATURES];
    int         magic_len [NUM_SIGNATURES];
    bit [111:0] magic_pat [NUM_SIGNATURES];

    t_head_byte file_bytes [$];
    t_match     expected_matches [$];
    t_flow_mode flow_mode = FLOW_FREE;
    int         bytes_queued   = 0;
    int         bytes_accepted = 0;
    int         error_count    = 0;
    logic       in_fire        = 1'b0;

    // predictor state
    int                      stream_pos  = 0;
    bit [NUM_SIGNATURES-1:0] rows_alive  = '1;

    bit [7:0] head_buf [HEAD_MAX];

    function automatic void set_row(int r, int off, int len, bit [111:0] pat);
        magic_off[r] = off;
        magic_len[r] = len;
        magic_pat[r] = pat;
    endfunction

    function automatic bit [7:0] magic_byte(int r, int k);
        return magic_pat[r][8*(magic_len[r]-1-k) +: 8];
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void predict_signature(bit [7:0] b, bit last);
        t_match res;
        int     r;
        for (r = 0; r < NUM_SIGNATURES; r++) begin
            if (stream_pos >= magic_off[r] && stream_pos < magic_off[r] + magic_len[r]) begin
                if (magic_byte(r, stream_pos - magic_off[r]) != b)
                    rows_alive[r] = 1'b0;
            end
        end
        if (!last) begin
            if (stream_pos < POSITION_LIMIT)
                stream_pos++;
        end else begin
            res = '0;
            // lowest row wins, and it must end strictly before the stream does
            for (r = 0; r < NUM_SIGNATURES; r++) begin
                if (!res.found && rows_alive[r] && magic_off[r] + magic_len[r] <= stream_pos) begin
                    res.found = 1'b1;
                    res.row   = r[5:0];
                end
            end
            expected_matches.push_back(res);
            stream_pos = 0;
            rows_alive = '1;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic push_byte(bit [7:0] b, bit last);
        t_head_byte hb;
        hb.data = b;
        hb.last = last;
        file_bytes.push_back(hb);
        bytes_queued++;
    endtask

    // pushes the n low bytes of v, most significant first
    task automatic push_bytes(bit [63:0] v, int n);
        int k;
        for (k = n - 1; k >= 0; k--)
            push_byte(v[8*k +: 8], k == 0);
    endtask

    task automatic place_magic(int r);
        int k;
        for (k = 0; k < magic_len[r]; k++)
            head_buf[magic_off[r] + k] = magic_byte(r, k);
    endtask

    task automatic queue_file_head(t_head_kind kind);
        int r;
        int r2;
        int len;
        int k;
        r = $urandom_range(0, NUM_SIGNATURES - 1);
        if (r == USTAR_ROW)
            r++;
        r2 = $urandom_range(0, NUM_SIGNATURES - 1);
        if (r2 == USTAR_ROW)
            r2--;
        for (k = 0; k < HEAD_MAX; k++)
            head_buf[k] = chance(25) ? 8'h00 : 8'($urandom_range(0, 255));
        // a zero extra byte makes the row end exactly at the stream end
        len = magic_off[r] + magic_len[r] + $urandom_range(0, 5);
        case (kind)
            HEAD_LONG: begin
                if (chance(50))
                    place_magic(r2);
                r   = USTAR_ROW;
                len = $urandom_range(262, 330);
                place_magic(r);
            end
            HEAD_MAGIC: begin
                place_magic(r);
            end
            HEAD_TWO_MAGIC: begin
                place_magic(r);
                place_magic(r2);
                if (magic_off[r2] + magic_len[r2] + 1 > len)
                    len = magic_off[r2] + magic_len[r2] + 1;
            end
            HEAD_CORRUPT: begin
                place_magic(r);
                k = magic_off[r] + $urandom_range(0, magic_len[r] - 1);
                head_buf[k][$urandom_range(0, 7)] ^= 1'b1;
            end
            default: begin
                len = $urandom_range(1, 16);
            end
        endcase
        for (k = 0; k < len; k++)
            push_byte(head_buf[k], k == len - 1);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (file_bytes.size() > 0 &&
                !(flow_mode == FLOW_SENDER_IDLE && chance(52)) &&
                !(flow_mode == FLOW_BOTH && chance(13))) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= file_bytes[0].data;
                s_axis_tlast  <= file_bytes[0].last;
                file_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (flow_mode == FLOW_RECEIVER_STALL)
            m_axis_tready <= !chance(52);
        else if (flow_mode == FLOW_BOTH)
            m_axis_tready <= !chance(13);
        else
            m_axis_tready <= 1'b1;
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_signature(s_axis_tdata, s_axis_tlast);
                bytes_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("unexpected result, row", m_axis_tdata, -1);
                end else begin
                    want = expected_matches.pop_front();
                    if (m_axis_tuser !== want.found)
                        report_mismatch("found", m_axis_tuser, want.found);
                    if (m_axis_tdata !== {2'b00, want.row})
                        report_mismatch("signature_row", m_axis_tdata, want.row);
                end
            end
        end
    end

    initial begin
        int         phase;
        int         phase_start;
        int         pick;
        t_head_kind kind;

        set_row(0, 28, 8, 64'h4F70757348656164);
        set_row(1, 0, 14, 112'h060E2B34020501010D0102010102);
        set_row(2, 0, 11, 88'h0000001C667479704D3456);
        set_row(3, 0, 10, 80'h3026B2758E66CF11A6D9);
        set_row(4, 0, 8, 64'h0000001466747970);
        set_row(5, 0, 8, 64'hD0CF11E0A1B11AE1);
        set_row(6, 0, 7, 56'h213C617263683E);
        set_row(7, 4, 7, 56'h667479704D3441);
        set_row(8, 0, 6, 48'h377ABCAF271C);
        set_row(9, 0, 6, 48'hFD377A585A00);
        set_row(10, 0, 5, 40'h2321414D52);
        set_row(11, 0, 5, 40'h7B5C727466);
        set_row(12, 257, 5, 40'h7573746172);
        set_row(13, 0, 5, 40'h0001000000);
        set_row(14, 0, 4, 32'h49536328);
        set_row(15, 0, 4, 32'h4D534346);
        set_row(16, 0, 4, 32'h43723234);
        set_row(17, 0, 4, 32'h664C6143);
        set_row(18, 0, 4, 32'h464C4946);
        set_row(19, 0, 4, 32'h464C5601);
        set_row(20, 0, 4, 32'h00000100);
        set_row(21, 0, 4, 32'h4C5A4950);
        set_row(22, 0, 4, 32'h4D344120);
        set_row(23, 0, 4, 32'h4D546864);
        set_row(24, 0, 4, 32'h1A45DFA3);
        set_row(25, 0, 4, 32'h33677035);
        set_row(26, 4, 4, 32'h66747970);
        set_row(27, 0, 4, 32'h00000162);
        set_row(28, 0, 4, 32'h4E45531A);
        set_row(29, 0, 4, 32'h4F676753);
        set_row(30, 0, 4, 32'h4F54544F);
        set_row(31, 0, 4, 32'h25504446);
        set_row(32, 0, 4, 32'h89504E47);
        set_row(33, 0, 4, 32'h38425053);
        set_row(34, 0, 4, 32'h52617221);
        set_row(35, 0, 4, 32'hEDABEEDB);
        set_row(36, 0, 4, 32'h53514C69);
        set_row(37, 0, 4, 32'h3C737667);
        set_row(38, 0, 4, 32'h49492A00);
        set_row(39, 0, 4, 32'h4D4D002A);
        set_row(40, 8, 4, 32'h57415645);
        set_row(41, 8, 4, 32'h57454250);
        set_row(42, 0, 4, 32'h774F4646);
        set_row(43, 0, 4, 32'h774F4632);
        set_row(44, 8, 3, 24'h415649);
        set_row(45, 0, 3, 24'h425A68);
        set_row(46, 0, 3, 24'h474946);
        set_row(47, 0, 3, 24'h1F8B08);
        set_row(48, 0, 3, 24'hFFD8FF);
        set_row(49, 0, 3, 24'h4949BC);
        set_row(50, 0, 3, 24'h494433);
        set_row(51, 0, 2, 16'h424D);
        set_row(52, 0, 2, 16'h7801);
        set_row(53, 0, 2, 16'h4D5A);
        set_row(54, 0, 2, 16'h2521);
        set_row(55, 1, 2, 16'h5753);
        set_row(56, 0, 2, 16'h1F9D);
        set_row(57, 0, 2, 16'h1FA0);
        set_row(58, 0, 2, 16'h504B);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            flow_mode   = t_flow_mode'(phase);
            phase_start = bytes_queued;
            if (phase == 0) begin
                // single byte streams can never match
                push_bytes(64'h00, 1);
                push_bytes(64'hFF, 1);
                // a row ending at the last byte is not enough
                push_bytes(64'h504B, 2);
                push_bytes(64'h504B41, 3);
                push_bytes(64'h89504E4700, 5);
                push_bytes(64'hFFD8FFE0, 4);
                push_bytes(64'h7B5C72746631, 6);
            end
            // long heads saturate the position and reach the tar row
            if (phase % 2 == 0)
                queue_file_head(HEAD_LONG);
            while (bytes_queued - phase_start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    kind = HEAD_MAGIC;
                else if (pick < 70)
                    kind = HEAD_TWO_MAGIC;
                else if (pick < 85)
                    kind = HEAD_CORRUPT;
                else if (pick < 99)
                    kind = HEAD_NOISE;
                else
                    kind = HEAD_LONG;
                queue_file_head(kind);
            end
            // hold off the next phase until every result is back
            while (bytes_accepted != bytes_queued || expected_matches.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (expected_matches.size() != 0) begin
            report_mismatch("missing result, row", -1, expected_matches[0].row);
            void'(expected_matches.pop_front());
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
